[rtl/ttavg_pkg.sv]
// Shared types, codes and constants of the thermistor temperature averager.
package ttavg_pkg;

   localparam int AVERAGE_DEPTH_DEF  = 5;
   localparam int ADC_FULL_SCALE_DEF = 1023;

   localparam int ADC_W   = 10;
   localparam int TEMP_W  = 18;
   localparam int CSR_W   = 20;
   localparam int CSR_IDX_W = 3;
   localparam int MUL_W   = 32;
   localparam int DIV_W   = 54;

   localparam logic [CSR_IDX_W-1:0] REG_SERIES   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BETA     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_NOMINAL  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_NOM_TEMP = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_ADC  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_ADC  = 3'd5;

   localparam logic signed [TEMP_W-1:0] TEMP_FAULT = 18'sd66600;
   localparam logic signed [TEMP_W-1:0] TEMP_MAX   = 18'sd66600;
   localparam logic signed [TEMP_W-1:0] TEMP_MIN   = -18'sd27315;
   localparam logic [16:0] KELVIN_OFFSET = 17'd27315;
   // Largest absolute quotient that still maps at or below the upper clamp.
   localparam logic [DIV_W-1:0] Q_LIMIT = 54'd93915;
   localparam logic [MUL_W-1:0] LN2_Q30 = 32'd744261118;
   localparam logic [MUL_W-1:0] CENTI   = 32'd100;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_XS_MUL,
      ST_XS_RES,
      ST_NORM,
      ST_SQ_MUL,
      ST_SQ_RES,
      ST_LOG_ACC,
      ST_LN_MUL,
      ST_LN_RES,
      ST_BT_MUL,
      ST_BT_RES,
      ST_N_MUL,
      ST_N_RES,
      ST_B100_MUL,
      ST_B100_RES,
      ST_TL_MUL,
      ST_TL_RES,
      ST_DIV_WAIT,
      ST_RING_WR,
      ST_SUM,
      ST_MEAN_DIV,
      ST_MEAN_WAIT,
      ST_OUT
   } state_type;

endpackage

[rtl/ttavg_req_if.sv]
// Request channel: one ADC sample per beat.
interface ttavg_req_if;
   logic                          valid;
   logic                          ready;
   logic [ttavg_pkg::ADC_W-1:0]   adc_sample;

   modport source (output valid, output adc_sample, input ready);
   modport sink   (input valid, input adc_sample, output ready);
endinterface

[rtl/ttavg_rsp_if.sv]
// Response channel: sample temperature and moving mean per beat.
interface ttavg_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [ttavg_pkg::TEMP_W-1:0]  sample_temp;
   logic signed [ttavg_pkg::TEMP_W-1:0]  mean_temp;
   logic                                 mean_valid;
   logic                                 in_range;

   modport source (output valid, output sample_temp, output mean_temp,
                   output mean_valid, output in_range, input ready);
   modport sink   (input valid, input sample_temp, input mean_temp,
                   input mean_valid, input in_range, output ready);
endinterface

[rtl/thermistor_temp_averager.sv]
// Thermistor beta-equation temperature with a moving average, top level.
//
//   channel  | direction | beat carries
//   req_if   | in        | adc_sample
//   rsp_if   | out       | sample_temp, mean_temp, mean_valid, in_range
//   csr_*    | in        | register writes, no read-back
//
// A sample in the window is normalized and squared for each of three base-2 logarithms,
// then passes the products, a beta divide unless the denominator is not positive, and a
// ring write; once the ring is primed a summing pass and a reciprocal multiply follow for
// the mean. A fault or degenerate sample goes straight to the ring write, and on to the
// same summing pass once primed. req_if.ready is high only while idle; a result holds on
// rsp_if until taken.
module thermistor_temp_averager #(
   parameter int AVERAGE_DEPTH  = ttavg_pkg::AVERAGE_DEPTH_DEF,
   parameter int ADC_FULL_SCALE = ttavg_pkg::ADC_FULL_SCALE_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   ttavg_req_if.sink                         req_if,
   ttavg_rsp_if.source                       rsp_if,
   input  logic                              csr_we,
   input  logic [ttavg_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ttavg_pkg::CSR_W-1:0]       csr_wdata
);
   import ttavg_pkg::*;

   localparam int IDX_W  = (AVERAGE_DEPTH > 1) ? $clog2(AVERAGE_DEPTH) : 1;
   localparam int PRIM_W = $clog2(AVERAGE_DEPTH + 1);
   localparam int SUM_W  = TEMP_W + $clog2(AVERAGE_DEPTH) + 1;
   localparam logic [15:0] FULL_SCALE = 16'(ADC_FULL_SCALE);
   // The mean is the rounded sum times ceil(2^31 / AVERAGE_DEPTH), keeping bit 31 and above.
   localparam logic [MUL_W-1:0] MEAN_RECIP =
      MUL_W'(((64'd1 << 31) + 64'(AVERAGE_DEPTH) - 64'd1) / 64'(AVERAGE_DEPTH));

   // Configuration registers.
   logic [19:0]        series_ff;
   logic [13:0]        beta_ff;
   logic [19:0]        nominal_ff;
   logic signed [14:0] nom_temp_ff;
   logic [9:0]         min_adc_ff;
   logic [9:0]         max_adc_ff;

   state_type state_ff, state_in;

   logic [ADC_W-1:0]          s_ff;
   logic [31:0]               y_ff;
   logic [4:0]                pcnt_ff;
   logic [15:0]               frac_ff;
   logic [3:0]                iter_ff;
   logic [1:0]                lsel_ff;
   logic signed [22:0]        lacc_ff;
   logic [21:0]               lnmag_ff;
   logic                      ln_neg_ff;
   logic [31:0]               p1_ff;
   logic [DIV_W-1:0]          n_ff;
   logic signed [39:0]        d_ff;
   logic signed [TEMP_W-1:0]  t_ff;
   logic signed [TEMP_W-1:0]  mean_ff;
   logic                      mean_valid_ff;
   logic                      ok_ff;
   logic signed [TEMP_W-1:0]  ring_ff [AVERAGE_DEPTH];
   logic [IDX_W-1:0]          widx_ff;
   logic [IDX_W-1:0]          sptr_ff;
   logic [PRIM_W-1:0]         prime_ff;
   logic signed [SUM_W-1:0]   acc_ff;

   logic [MUL_W-1:0]   mul_a, mul_b;
   logic [2*MUL_W-1:0] mul_p;
   logic               div_start;
   logic               div_done;
   logic [DIV_W-1:0]   div_num, div_den, div_q;

   logic               accept;
   logic               ok_w;
   logic               degen_w;
   logic [16:0]        t0c;
   logic [32:0]        sq_shift;
   logic [20:0]        log_val;
   logic signed [39:0] d_next;
   logic [SUM_W-1:0]   acc_abs;

   assign accept  = req_if.valid && req_if.ready;
   assign ok_w    = !(req_if.adc_sample < min_adc_ff || req_if.adc_sample > max_adc_ff);
   assign degen_w = (req_if.adc_sample == '0) || (16'(req_if.adc_sample) >= FULL_SCALE)
                    || (series_ff == '0) || (nominal_ff == '0);
   assign t0c      = {{2{nom_temp_ff[14]}}, nom_temp_ff} + KELVIN_OFFSET;
   assign sq_shift = mul_p[63:31];
   assign log_val  = {pcnt_ff, frac_ff};
   assign d_next   = ln_neg_ff ? d_ff - $signed({2'b00, mul_p[37:0]})
                               : d_ff + $signed({2'b00, mul_p[37:0]});
   assign acc_abs  = acc_ff[SUM_W-1] ? SUM_W'(-acc_ff) : acc_ff;

   ttavg_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (mul_p)
   );

   ttavg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_q)
   );

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         series_ff   <= 20'd10000;
         beta_ff     <= 14'd3950;
         nominal_ff  <= 20'd10000;
         nom_temp_ff <= 15'sd2500;
         min_adc_ff  <= 10'd0;
         max_adc_ff  <= 10'd1023;
      end else if (csr_we) begin
         case (csr_index)
            REG_SERIES:   series_ff   <= csr_wdata;
            REG_BETA:     beta_ff     <= csr_wdata[13:0];
            REG_NOMINAL:  nominal_ff  <= csr_wdata;
            REG_NOM_TEMP: nom_temp_ff <= $signed(csr_wdata[14:0]);
            REG_MIN_ADC:  min_adc_ff  <= csr_wdata[9:0];
            REG_MAX_ADC:  max_adc_ff  <= csr_wdata[9:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      mul_a     = '0;
      mul_b     = '0;
      div_start = 1'b0;
      div_num   = DIV_W'(n_ff) + DIV_W'(d_ff[38:1]);
      div_den   = DIV_W'(d_ff[38:0]);
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (!ok_w || degen_w) ? ST_RING_WR : ST_XS_MUL;
            end
         end
         ST_XS_MUL: begin
            mul_a    = 32'(series_ff);
            mul_b    = 32'(s_ff);
            state_in = ST_XS_RES;
         end
         ST_XS_RES: state_in = ST_NORM;
         ST_NORM: begin
            if (y_ff[31]) begin
               state_in = ST_SQ_MUL;
            end
         end
         ST_SQ_MUL: begin
            mul_a    = y_ff;
            mul_b    = y_ff;
            state_in = ST_SQ_RES;
         end
         ST_SQ_RES: state_in = (iter_ff == 4'd15) ? ST_LOG_ACC : ST_SQ_MUL;
         ST_LOG_ACC: state_in = (lsel_ff == 2'd2) ? ST_LN_MUL : ST_NORM;
         ST_LN_MUL: begin
            mul_a    = 32'(lacc_ff[22] ? -lacc_ff : lacc_ff);
            mul_b    = LN2_Q30;
            state_in = ST_LN_RES;
         end
         ST_LN_RES: state_in = ST_BT_MUL;
         ST_BT_MUL: begin
            mul_a    = 32'(beta_ff);
            mul_b    = 32'(t0c);
            state_in = ST_BT_RES;
         end
         ST_BT_RES: state_in = ST_N_MUL;
         ST_N_MUL: begin
            mul_a    = p1_ff;
            mul_b    = CENTI;
            state_in = ST_N_RES;
         end
         ST_N_RES: state_in = ST_B100_MUL;
         ST_B100_MUL: begin
            mul_a    = 32'(beta_ff);
            mul_b    = CENTI;
            state_in = ST_B100_RES;
         end
         ST_B100_RES: state_in = ST_TL_MUL;
         ST_TL_MUL: begin
            mul_a    = 32'(t0c);
            mul_b    = 32'(lnmag_ff);
            state_in = ST_TL_RES;
         end
         ST_TL_RES: state_in = (d_next <= 0) ? ST_RING_WR : ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (div_done) begin
               state_in = ST_RING_WR;
            end
         end
         ST_RING_WR: state_in = (prime_ff < PRIM_W'(AVERAGE_DEPTH)) ? ST_OUT : ST_SUM;
         ST_SUM: begin
            if (sptr_ff == IDX_W'(AVERAGE_DEPTH - 1)) begin
               state_in = ST_MEAN_DIV;
            end
         end
         ST_MEAN_DIV: begin
            mul_a    = MUL_W'(acc_abs) + MUL_W'(AVERAGE_DEPTH / 2);
            mul_b    = MEAN_RECIP;
            state_in = ST_MEAN_WAIT;
         end
         ST_MEAN_WAIT: state_in = ST_OUT;
         ST_OUT: begin
            if (rsp_if.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      // The beta divide starts as the denominator settles positive.
      if (state_ff == ST_TL_RES && d_next > 0) begin
         div_start = 1'b1;
         div_num   = DIV_W'(n_ff) + DIV_W'(d_next[38:1]);
         div_den   = DIV_W'(d_next[38:0]);
      end
   end

   // Ring writes and control counters of the ring.
   always_ff @(posedge clock) begin
      if (reset) begin
         widx_ff  <= '0;
         prime_ff <= '0;
         for (int i = 0; i < AVERAGE_DEPTH; i++) begin
            ring_ff[i] <= '0;
         end
      end else if (state_ff == ST_RING_WR) begin
         ring_ff[widx_ff] <= t_ff;
         widx_ff <= (widx_ff == IDX_W'(AVERAGE_DEPTH - 1)) ? '0 : widx_ff + 1'b1;
         if (prime_ff < PRIM_W'(AVERAGE_DEPTH)) begin
            prime_ff <= prime_ff + 1'b1;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               s_ff    <= req_if.adc_sample;
               ok_ff   <= ok_w;
               lsel_ff <= 2'd0;
               lacc_ff <= '0;
               t_ff    <= ok_w ? TEMP_MIN : TEMP_FAULT;
            end
         end
         ST_XS_RES: begin
            y_ff    <= mul_p[31:0];
            pcnt_ff <= 5'd31;
         end
         ST_NORM: begin
            frac_ff <= '0;
            iter_ff <= '0;
            if (!y_ff[31]) begin
               y_ff    <= {y_ff[30:0], 1'b0};
               pcnt_ff <= pcnt_ff - 1'b1;
            end
         end
         ST_SQ_RES: begin
            iter_ff <= iter_ff + 1'b1;
            if (sq_shift[32]) begin
               y_ff    <= sq_shift[32:1];
               frac_ff <= {frac_ff[14:0], 1'b1};
            end else begin
               y_ff    <= sq_shift[31:0];
               frac_ff <= {frac_ff[14:0], 1'b0};
            end
         end
         ST_LOG_ACC: begin
            lsel_ff <= lsel_ff + 1'b1;
            pcnt_ff <= 5'd31;
            if (lsel_ff == 2'd0) begin
               lacc_ff <= lacc_ff + $signed({2'b00, log_val});
               y_ff    <= 32'(FULL_SCALE - 16'(s_ff));
            end else begin
               lacc_ff <= lacc_ff - $signed({2'b00, log_val});
               y_ff    <= 32'(nominal_ff);
            end
         end
         ST_LN_RES: begin
            lnmag_ff  <= 22'((mul_p + 64'(32'h2000_0000)) >> 30);
            ln_neg_ff <= lacc_ff[22];
         end
         ST_BT_RES: p1_ff <= mul_p[31:0];
         ST_N_RES: n_ff <= {mul_p[37:0], 16'b0};
         ST_B100_RES: d_ff <= $signed({3'b000, mul_p[20:0], 16'b0});
         ST_TL_RES: begin
            d_ff <= d_next;
            if (d_next <= 0) begin
               t_ff <= (d_next == 0 && beta_ff != '0) ? TEMP_MAX : TEMP_MIN;
            end
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               t_ff <= (div_q > Q_LIMIT) ? TEMP_MAX
                       : $signed({1'b0, div_q[16:0]} - 18'(KELVIN_OFFSET));
            end
         end
         ST_RING_WR: begin
            acc_ff        <= '0;
            sptr_ff       <= '0;
            mean_ff       <= '0;
            mean_valid_ff <= 1'b0;
         end
         ST_SUM: begin
            acc_ff  <= acc_ff + SUM_W'(ring_ff[sptr_ff]);
            sptr_ff <= sptr_ff + 1'b1;
         end
         ST_MEAN_WAIT: begin
            mean_ff       <= acc_ff[SUM_W-1] ? -$signed(mul_p[TEMP_W+30:31])
                                             : $signed(mul_p[TEMP_W+30:31]);
            mean_valid_ff <= 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign req_if.ready       = (state_ff == ST_IDLE);
   assign rsp_if.valid       = (state_ff == ST_OUT);
   assign rsp_if.sample_temp = t_ff;
   assign rsp_if.mean_temp   = mean_ff;
   assign rsp_if.mean_valid  = mean_valid_ff;
   assign rsp_if.in_range    = ok_ff;
endmodule

[rtl/ttavg_mul.sv]
// Shared unsigned multiplier with a registered product.
module ttavg_mul (
   input  logic                              clock,
   input  logic [ttavg_pkg::MUL_W-1:0]       op_a,
   input  logic [ttavg_pkg::MUL_W-1:0]       op_b,
   output logic [2*ttavg_pkg::MUL_W-1:0]     product
);
   import ttavg_pkg::*;

   logic [2*MUL_W-1:0] product_ff;

   always_ff @(posedge clock) begin
      product_ff <= op_a * op_b;
   end

   assign product = product_ff;
endmodule

[rtl/ttavg_div.sv]
// Restoring divider that retires one quotient bit per cycle while busy.
module ttavg_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ttavg_pkg::DIV_W-1:0]   dividend,
   input  logic [ttavg_pkg::DIV_W-1:0]   divisor,
   output logic                          done,
   output logic [ttavg_pkg::DIV_W-1:0]   quotient
);
   import ttavg_pkg::*;

   localparam int CNT_W = $clog2(DIV_W);

   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] quo_ff;
   logic [DIV_W-1:0] dvs_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [DIV_W:0]   trial;
   logic             take;

   always_comb begin
      trial  = {rem_ff, quo_ff[DIV_W-1]};
      take   = trial >= {1'b0, dvs_ff};
      rem_in = take ? DIV_W'(trial - {1'b0, dvs_ff}) : trial[DIV_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[DIV_W-2:0], take};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

[rtl/ttavg_check.sv]
// Port-level checks of the thermistor averager, bound to the top level.
module ttavg_check (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [ttavg_pkg::TEMP_W-1:0] sample_temp,
   input logic signed [ttavg_pkg::TEMP_W-1:0] mean_temp,
   input logic                                mean_valid,
   input logic                                in_range
);
   import ttavg_pkg::*;

   // A stalled result beat holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(sample_temp) && $stable(mean_temp))
      else $error("result beat changed while stalled");

   // Only one sample is in work at a time.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready stayed high after a request beat");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request accepted while a result is pending");

   a_mean_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !mean_valid |-> mean_temp == '0)
      else $error("mean nonzero before the ring is primed");

   a_fault_temp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !in_range |-> sample_temp == TEMP_FAULT)
      else $error("fault sample without fault temperature");
endmodule

bind thermistor_temp_averager ttavg_check u_ttavg_check (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_if.valid),
   .req_ready   (req_if.ready),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .sample_temp (rsp_if.sample_temp),
   .mean_temp   (rsp_if.mean_temp),
   .mean_valid  (rsp_if.mean_valid),
   .in_range    (rsp_if.in_range)
);

[dv/thermistor_temp_averager_tb.sv]
// Testbench of the thermistor temperature averager: random and directed samples checked against a predictor.
`timescale 1ns / 100ps

module thermistor_temp_averager_tb;
   import ttavg_pkg::*;

   localparam int RING_DEPTH   = AVERAGE_DEPTH_DEF;
   localparam int FULL_SCALE   = ADC_FULL_SCALE_DEF;
   localparam int SETTLE_WAIT  = 400;
   localparam int CYCLE_LIMIT  = 3000000;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS  = 165;
   localparam int DIRECTED_N   = 13;
   localparam logic [ADC_W-1:0] DIRECTED_CODES [DIRECTED_N] = '{
      10'd0, 10'd1, 10'd2, 10'd5, 10'd256, 10'd341, 10'd511, 10'd512, 10'd682, 10'd768,
      10'd1021, 10'd1022, 10'd1023};

   typedef struct {
      logic signed [TEMP_W-1:0] sample_temp;
      logic signed [TEMP_W-1:0] mean_temp;
      logic                     mean_valid;
      logic                     in_range;
   } temp_beat_t;

   class temp_scoreboard;
      int unsigned series_ohm, beta_k, nominal_ohm, window_lo, window_hi;
      int          nominal_cc;
      int          ring[RING_DEPTH];
      int unsigned ring_pos, primed;
      temp_beat_t  expected_q[$];
      int          errors;

      function void reset_state();
         series_ohm = 10000; beta_k = 3950; nominal_ohm = 10000; nominal_cc = 2500;
         window_lo = 0; window_hi = 1023;
         foreach (ring[i]) ring[i] = 0;
         ring_pos = 0; primed = 0; errors = 0;
         expected_q.delete();
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] val);
         case (idx)
            REG_SERIES:   series_ohm  = val[19:0];
            REG_BETA:     beta_k      = val[13:0];
            REG_NOMINAL:  nominal_ohm = val[19:0];
            REG_NOM_TEMP: nominal_cc  = $signed(val[14:0]);
            REG_MIN_ADC:  window_lo   = val[9:0];
            REG_MAX_ADC:  window_hi   = val[9:0];
            default: ;
         endcase
      endfunction

      // Truncated Q16 base-2 logarithm by repeated squaring.
      function longint log2_q16(longint unsigned x);
         int unsigned    p;
         longint unsigned y;
         longint unsigned frac;
         p = 0;
         frac = 0;
         while (p < 63 && (x >> (p + 1)) != 0) p++;
         if (p >= 31) y = x >> (p - 31);
         else y = x << (31 - p);
         for (int i = 0; i < 16; i++) begin
            y = (y * y) >> 31;
            frac = frac << 1;
            if (y >= 64'h1_0000_0000) begin
               y = y >> 1;
               frac = frac | 1;
            end
         end
         return longint'(p) * 65536 + longint'(frac);
      endfunction

      function int beta_temp(int unsigned s);
         longint          l, lnq, t0c, n, d, tc;
         longint unsigned mag;
         if (s == 0 || s >= FULL_SCALE || series_ohm == 0 || nominal_ohm == 0)
            return -27315;
         l = log2_q16(longint'(series_ohm) * s) - log2_q16(FULL_SCALE - s)
             - log2_q16(nominal_ohm);
         mag = (l < 0) ? -l : l;
         mag = (mag * 64'd744261118 + (64'd1 << 29)) >> 30;
         lnq = (l < 0) ? -longint'(mag) : longint'(mag);
         t0c = nominal_cc + 27315;
         n = longint'(beta_k) * t0c * 6553600;
         d = longint'(beta_k) * 6553600 + t0c * lnq;
         if (d <= 0) return (d == 0 && n > 0) ? 66600 : -27315;
         tc = (n + d / 2) / d - 27315;
         if (tc > 66600) tc = 66600;
         if (tc < -27315) tc = -27315;
         return int'(tc);
      endfunction

      function void note_sample(logic [ADC_W-1:0] s);
         temp_beat_t      b;
         bit              ok;
         int              t;
         longint          sum;
         longint unsigned m;
         ok = !(s < window_lo || s > window_hi);
         t = ok ? beta_temp(s) : 66600;
         ring[ring_pos] = t;
         ring_pos = (ring_pos + 1) % RING_DEPTH;
         b.mean_temp = '0;
         b.mean_valid = 1'b0;
         if (primed < RING_DEPTH) begin
            primed++;
         end else begin
            sum = 0;
            foreach (ring[i]) sum += ring[i];
            m = (sum < 0) ? -sum : sum;
            m = (m + RING_DEPTH / 2) / RING_DEPTH;
            b.mean_temp = TEMP_W'((sum < 0) ? -longint'(m) : longint'(m));
            b.mean_valid = 1'b1;
         end
         b.sample_temp = TEMP_W'(t);
         b.in_range = ok;
         expected_q.push_back(b);
      endfunction

      function void check_result(temp_beat_t got);
         temp_beat_t want;
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected beat: sample %0d mean %0d", got.sample_temp, got.mean_temp);
            return;
         end
         want = expected_q.pop_front();
         if (got.sample_temp !== want.sample_temp || got.mean_temp !== want.mean_temp ||
             got.mean_valid !== want.mean_valid || got.in_range !== want.in_range) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: exp temp %0d mean %0d mv %0b ir %0b, got %0d %0d %0b %0b",
                        want.sample_temp, want.mean_temp, want.mean_valid, want.in_range,
                        got.sample_temp, got.mean_temp, got.mean_valid, got.in_range);
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;
   int unsigned          cycle_count;
   int unsigned          burst_left;
   bit                   gapless;
   int unsigned          stall_mode;
   temp_scoreboard       sb;

   ttavg_req_if req ();
   ttavg_rsp_if rsp ();

   thermistor_temp_averager dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req),
      .rsp_if    (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("thermistor_temp_averager_tb: errors");
         $finish;
      end
   end

   // Receiver stall pattern: the ready mode is drawn anew at regular intervals.
   always @(posedge clock) begin
      if (cycle_count % 300 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0: rsp.ready <= 1'b1;
         1: rsp.ready <= 1'($urandom_range(0, 1));
         2: rsp.ready <= (cycle_count % 7) < 3;
         default: rsp.ready <= ($urandom_range(0, 9) != 0);
      endcase
   end

   always @(posedge clock) begin
      temp_beat_t got;
      if (!reset && rsp.valid && rsp.ready) begin
         got.sample_temp = rsp.sample_temp;
         got.mean_temp = rsp.mean_temp;
         got.mean_valid = rsp.mean_valid;
         got.in_range = rsp.in_range;
         sb.check_result(got);
      end
   end

   task automatic push_sample(input logic [ADC_W-1:0] s);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         if (!gapless) begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
      burst_left--;
      req.valid <= 1'b1;
      req.adc_sample <= s;
      do @(posedge clock); while (!(req.valid && req.ready));
      sb.note_sample(s);
   endtask

   // Waits until every expected beat is back, then lets the block settle.
   task automatic drain_block();
      req.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.write_reg(idx, val);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_settings(input int unsigned phase);
      int unsigned lo, hi;
      case (phase % 4)
         0: write_csr(REG_SERIES, 20'd1);
         1: write_csr(REG_SERIES, 20'd1000000);
         2: write_csr(REG_SERIES, CSR_W'($urandom_range(0, 20'hFFFFF)));
         default: write_csr(REG_SERIES, CSR_W'($urandom_range(1000, 100000)));
      endcase
      case (phase % 3)
         0: write_csr(REG_BETA, 20'd10000);
         1: write_csr(REG_BETA, CSR_W'($urandom_range(0, 14'h3FFF)));
         default: write_csr(REG_BETA, CSR_W'($urandom_range(1, 10000)));
      endcase
      write_csr(REG_NOMINAL, (phase % 4 == 1) ? 20'd1 : CSR_W'($urandom_range(1, 1000000)));
      case (phase % 4)
         0: write_csr(REG_NOM_TEMP, CSR_W'(15'h7FFF & -5000));
         1: write_csr(REG_NOM_TEMP, 20'd15000);
         2: write_csr(REG_NOM_TEMP, CSR_W'($urandom_range(0, 15'h7FFF)));
         default: write_csr(REG_NOM_TEMP, CSR_W'($urandom_range(0, 10000)));
      endcase
      lo = $urandom_range(0, 200);
      hi = $urandom_range(800, 1023);
      if (phase == 5) begin
         lo = 700;
         hi = 300;
      end else if (phase % 2 == 0) begin
         lo = 0;
         hi = 1023;
      end
      write_csr(REG_MIN_ADC, CSR_W'(lo));
      write_csr(REG_MAX_ADC, CSR_W'(hi));
   endtask

   initial begin
      sb = new();
      sb.reset_state();
      burst_left = 0;
      gapless = 1'b0;
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      req.valid <= 1'b0;
      req.adc_sample <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIRECTED_N; i++) push_sample(DIRECTED_CODES[i]);
      drain_block();
      // Degenerate resistances and an inverted window.
      write_csr(REG_SERIES, 20'd0);
      push_sample(10'd500);
      drain_block();
      write_csr(REG_SERIES, 20'd10000);
      write_csr(REG_NOMINAL, 20'd0);
      push_sample(10'd500);
      drain_block();
      write_csr(REG_MIN_ADC, 20'd600);
      write_csr(REG_MAX_ADC, 20'd400);
      push_sample(10'd500);
      push_sample(10'd0);
      drain_block();
      // A tiny beta with a very low resistance drives the denominator negative.
      write_csr(REG_MIN_ADC, 20'd0);
      write_csr(REG_MAX_ADC, 20'd1023);
      write_csr(REG_NOMINAL, 20'd1000000);
      write_csr(REG_SERIES, 20'd1);
      write_csr(REG_BETA, 20'd1);
      write_csr(REG_NOM_TEMP, CSR_W'(15'h7FFF & -5000));
      push_sample(10'd1);
      push_sample(10'd1022);
      push_sample(10'd512);
      drain_block();

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         random_settings(ph);
         gapless = (ph % 3 == 2);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if ($urandom_range(0, 15) == 0)
               push_sample(($urandom_range(0, 1) != 0) ? 10'd1023 : 10'd0);
            else
               push_sample(ADC_W'($urandom_range(0, 1023)));
         end
         drain_block();
      end

      if (sb.errors == 0)
         $display("thermistor_temp_averager_tb: clean");
      else
         $display("thermistor_temp_averager_tb: errors");
      $finish;
   end

endmodule
